// ===== src/encoder_multiturn_velocity_unit_macros.svh =====
// Assertion macros for the encoder multi-turn velocity unit.
// Expects signals named clock and reset in the module that uses them.
`ifndef ENCODER_MULTITURN_VELOCITY_UNIT_MACROS_SVH
`define ENCODER_MULTITURN_VELOCITY_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define EMV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent
`define EMV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/emv_pkg.sv =====
// Shared widths, register indexes and constants for the encoder velocity unit.
// No dependencies; used by the channel interfaces and the top level.
package emv_pkg;

   // Field widths
   localparam int ANGLE_W  = 14;
   localparam int POS_W    = 32;
   localparam int WORD_W   = 16;
   localparam int STAMP_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COUNTS_PER_REV  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WRAP_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_DFLT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIX_POS_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FIX_HIGH        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FIX_NEG_LOW     = 3'd6;

   // Reset values of the configuration registers
   localparam logic [14:0] CPR_RESET       = 15'd16384;
   localparam logic [14:0] WRAP_RESET      = 15'd13107;
   localparam logic [31:0] IVL_MAX_RESET   = 32'd500000;
   localparam logic [19:0] IVL_DFLT_RESET  = 20'd100;
   localparam logic [15:0] FIX_POS_RESET   = 16'd13768;
   localparam logic [15:0] FIX_HIGH_RESET  = 16'd21591;
   localparam logic [15:0] FIX_NEG_RESET   = 16'd11160;

   // Microseconds per second, multiplied in one bit per cycle
   localparam int             MUL_K_W = 20;
   localparam logic [MUL_K_W-1:0] MUL_K = 20'd1000000;

endpackage

// ===== src/emv_req_if.sv =====
// Input channel of the encoder velocity unit: one sample word and its timestamp.
// Depends on emv_pkg for field widths.
interface emv_req_if import emv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    sample_word;
   logic [STAMP_W-1:0]   timestamp_us;

   modport source (output valid, output sample_word, output timestamp_us, input ready);
   modport sink   (input valid, input sample_word, input timestamp_us, output ready);
endinterface

// ===== src/emv_rsp_if.sv =====
// Result channel of the encoder velocity unit: angle, position, velocity and flags.
// Depends on emv_pkg for field widths.
interface emv_rsp_if import emv_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic        [ANGLE_W-1:0] angle_counts;
   logic signed [POS_W-1:0]   position_counts;
   logic signed [31:0]        velocity_cps;
   logic                      parity_ok;
   logic                      no_magnet;
   logic        [31:0]        interval_us;

   modport source (output valid, output angle_counts, output position_counts,
                   output velocity_cps, output parity_ok, output no_magnet,
                   output interval_us, input ready);
   modport sink   (input valid, input angle_counts, input position_counts,
                   input velocity_cps, input parity_ok, input no_magnet,
                   input interval_us, output ready);
endinterface

// ===== src/encoder_multiturn_velocity_unit.sv =====
// Multi-turn encoder position and velocity unit: sequencer, bit-serial multiply, divider.
// Depends on emv_pkg, emv_req_if, emv_rsp_if and the assertion macro header.
//
//   channel   direction  handshake         contents
//   req_chan  in         valid / ready     sample_word, timestamp_us
//   rsp_chan  out        valid / ready     angle, position, velocity, flags, interval
//   csr_*     in         csr_we only       register index and write data
//
// Each item passes through 6 setup steps, 20 steps of the bit-serial multiply by one
// million, the saturation check and, when the velocity does not saturate, 31 steps
// of the radix-2 divider, then the result step.
// One item is in work at a time; req_chan.ready is high while the sequencer is idle,
// also while a finished result waits in the output register.
// A stalled rsp_chan holds the sequencer in its last step until the register frees.
// Reset is synchronous and restores the register defaults and the tracking state.
`include "encoder_multiturn_velocity_unit_macros.svh"

module encoder_multiturn_velocity_unit import emv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   emv_req_if.sink              req_chan,
   emv_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // Sequencer steps
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FRONT = 4'd1;
   localparam logic [3:0] S_POS   = 4'd2;
   localparam logic [3:0] S_DELTA = 4'd3;
   localparam logic [3:0] S_FIX1  = 4'd4;
   localparam logic [3:0] S_FIX2  = 4'd5;
   localparam logic [3:0] S_MAG   = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_CHK   = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam logic [4:0] MUL_LAST = 5'(MUL_K_W - 1);
   localparam logic [4:0] DIV_LAST = 5'd30;

   // Configuration registers
   logic [14:0] cpr_ff;
   logic [14:0] wrap_thr_ff;
   logic [31:0] ivl_max_ff;
   logic [19:0] ivl_dflt_ff;
   logic [15:0] fix_pos_low_ff;
   logic [15:0] fix_high_ff;
   logic [15:0] fix_neg_low_ff;

   // Tracking state
   logic [ANGLE_W-1:0] angle_now_ff, angle_now_in;
   logic [ANGLE_W-1:0] angle_last_ff, angle_last_in;
   logic               magnet_ff, magnet_in;
   logic [POS_W-1:0]   turn_ff, turn_in;
   logic [POS_W-1:0]   pos_last_ff, pos_last_in;
   logic [31:0]        time_last_ff, time_last_in;
   logic               primed_ff, primed_in;

   // Sequencer and work registers
   logic [3:0]          state_ff, state_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [31:0]         stamp_ff, stamp_in;
   logic                ok_ff, ok_in;
   logic                first_ff, first_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [31:0]         dt_ff, dt_in;
   logic signed [33:0]  delta_ff, delta_in;
   logic                neg_ff, neg_in;
   logic [32:0]         mag_ff, mag_in;
   logic [MUL_K_W-1:0]  kbits_ff, kbits_in;
   logic [51:0]         prod_ff, prod_in;
   logic [30:0]         low_ff, low_in;
   logic [31:0]         rem_ff, rem_in;
   logic [30:0]         quo_ff, quo_in;
   logic                sat_ff, sat_in;

   // Output register
   logic                     out_valid_ff, out_valid_in;
   logic [ANGLE_W-1:0]       out_angle_ff, out_angle_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   logic [31:0]              out_vel_ff, out_vel_in;
   logic                     out_ok_ff, out_ok_in;
   logic                     out_mag_ff, out_mag_in;
   logic [31:0]              out_ivl_ff, out_ivl_in;

   // Combinational helpers
   logic                 accept;
   logic                 out_free;
   logic                 parity_even;
   logic [ANGLE_W-1:0]   angle_sel;
   logic signed [15:0]   jump;
   logic signed [15:0]   wrap_thr_s;
   logic                 stamp_gt;
   logic [19:0]          dflt;
   logic signed [32:0]   delta_raw;
   logic signed [33:0]   fix_pos_low_s, fix_high_s, fix_neg_low_s, cpr_s;
   logic [32:0]          trial;
   logic [32:0]          trial_diff;
   logic                 trial_ge;
   logic [31:0]          quo_ext;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   assign parity_even = ~(^word_ff);
   assign angle_sel   = parity_even ? word_ff[WORD_W-1 -: ANGLE_W] : angle_now_ff;
   assign jump        = $signed({2'b00, angle_sel}) - $signed({2'b00, angle_last_ff});
   assign wrap_thr_s  = $signed({1'b0, wrap_thr_ff});
   assign stamp_gt    = stamp_ff > time_last_ff;
   assign dflt        = (ivl_dflt_ff == 20'd0) ? 20'd1 : ivl_dflt_ff;
   assign delta_raw   = $signed({pos_ff[POS_W-1], pos_ff})
                        - $signed({pos_last_ff[POS_W-1], pos_last_ff});

   assign fix_pos_low_s = $signed({18'd0, fix_pos_low_ff});
   assign fix_high_s    = $signed({18'd0, fix_high_ff});
   assign fix_neg_low_s = $signed({18'd0, fix_neg_low_ff});
   assign cpr_s         = $signed({19'd0, cpr_ff});

   assign trial      = {rem_ff, low_ff[30]};
   assign trial_diff = trial - {1'b0, dt_ff};
   assign trial_ge   = trial >= {1'b0, dt_ff};
   assign quo_ext    = {1'b0, quo_ff};

   // Sequencer: advance one step per cycle, hold in the last step while the output is full
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      word_in       = word_ff;
      stamp_in      = stamp_ff;
      ok_in         = ok_ff;
      first_in      = first_ff;
      pos_in        = pos_ff;
      dt_in         = dt_ff;
      delta_in      = delta_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      kbits_in      = kbits_ff;
      prod_in       = prod_ff;
      low_in        = low_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      sat_in        = sat_ff;
      angle_now_in  = angle_now_ff;
      angle_last_in = angle_last_ff;
      magnet_in     = magnet_ff;
      turn_in       = turn_ff;
      pos_last_in   = pos_last_ff;
      time_last_in  = time_last_ff;
      primed_in     = primed_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_angle_in  = out_angle_ff;
      out_pos_in    = out_pos_ff;
      out_vel_in    = out_vel_ff;
      out_ok_in     = out_ok_ff;
      out_mag_in    = out_mag_ff;
      out_ivl_in    = out_ivl_ff;

      case (state_ff)
         S_IDLE: begin
            // take the next item
            if (accept) begin
               word_in  = req_chan.sample_word;
               stamp_in = req_chan.timestamp_us;
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            // load angle and flag from a good sample, count a revolution on a large jump
            ok_in         = parity_even;
            angle_now_in  = angle_sel;
            angle_last_in = angle_sel;
            if (parity_even) begin
               magnet_in = word_ff[1];
            end
            if (jump > wrap_thr_s || -jump > wrap_thr_s) begin
               if (jump > 16'sd0) begin
                  turn_in = turn_ff - {17'd0, cpr_ff};
               end else begin
                  turn_in = turn_ff + {17'd0, cpr_ff};
               end
            end
            // elapsed time, wrapping past the top of the counter
            dt_in    = stamp_ff - time_last_ff - {31'd0, ~stamp_gt};
            state_in = S_POS;
         end
         S_POS: begin
            // form position, replace an unusable interval by the default
            pos_in   = turn_ff + {{(POS_W-ANGLE_W){1'b0}}, angle_now_ff};
            first_in = !primed_ff;
            if (!primed_ff || dt_ff == 32'd0 || dt_ff > ivl_max_ff) begin
               dt_in = {12'd0, dflt};
            end
            state_in = S_DELTA;
         end
         S_DELTA: begin
            delta_in     = {delta_raw[32], delta_raw};
            pos_last_in  = pos_ff;
            time_last_in = stamp_ff;
            primed_in    = 1'b1;
            state_in     = S_FIX1;
         end
         S_FIX1: begin
            // drop one revolution from a change just short of a positive turn
            if (delta_ff > fix_pos_low_s && delta_ff < fix_high_s) begin
               delta_in = delta_ff - cpr_s;
            end
            state_in = S_FIX2;
         end
         S_FIX2: begin
            // add one revolution to a change just short of a negative turn
            if (delta_ff > -fix_high_s && delta_ff < -fix_neg_low_s) begin
               delta_in = delta_ff + cpr_s;
            end
            state_in = S_MAG;
         end
         S_MAG: begin
            // split into sign and magnitude; the first item moves nothing
            neg_in = delta_ff[33] && !first_ff;
            if (first_ff) begin
               mag_in = 33'd0;
            end else if (delta_ff[33]) begin
               mag_in = 33'(-delta_ff);
            end else begin
               mag_in = delta_ff[32:0];
            end
            prod_in  = 52'd0;
            kbits_in = MUL_K;
            cnt_in   = MUL_LAST;
            state_in = S_MUL;
         end
         S_MUL: begin
            // shift-add one bit of the constant per cycle, most significant first
            prod_in  = {prod_ff[50:0], 1'b0} + (kbits_ff[MUL_K_W-1] ? {19'd0, mag_ff} : 52'd0);
            kbits_in = {kbits_ff[MUL_K_W-2:0], 1'b0};
            cnt_in   = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            // a quotient of 2^31 or more saturates; skip the divider then
            sat_in = {11'd0, prod_ff[51:31]} >= dt_ff;
            rem_in = {11'd0, prod_ff[51:31]};
            low_in = prod_ff[30:0];
            quo_in = 31'd0;
            cnt_in = DIV_LAST;
            if ({11'd0, prod_ff[51:31]} >= dt_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (trial_ge) begin
               rem_in = trial_diff[31:0];
            end else begin
               rem_in = trial[31:0];
            end
            quo_in = {quo_ff[29:0], trial_ge};
            low_in = {low_ff[29:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // load the result once the output register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_angle_in = angle_now_ff;
               out_pos_in   = pos_ff;
               out_ok_in    = ok_ff;
               out_mag_in   = magnet_ff;
               out_ivl_in   = dt_ff;
               if (sat_ff) begin
                  out_vel_in = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  out_vel_in = neg_ff ? (32'd0 - quo_ext) : quo_ext;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         out_valid_ff  <= 1'b0;
         angle_now_ff  <= '0;
         angle_last_ff <= '0;
         magnet_ff     <= 1'b0;
         turn_ff       <= '0;
         pos_last_ff   <= '0;
         time_last_ff  <= '0;
         primed_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         angle_now_ff  <= angle_now_in;
         angle_last_ff <= angle_last_in;
         magnet_ff     <= magnet_in;
         turn_ff       <= turn_in;
         pos_last_ff   <= pos_last_in;
         time_last_ff  <= time_last_in;
         primed_ff     <= primed_in;
      end
   end

   // Work and output payload registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      word_ff      <= word_in;
      stamp_ff     <= stamp_in;
      ok_ff        <= ok_in;
      first_ff     <= first_in;
      pos_ff       <= pos_in;
      dt_ff        <= dt_in;
      delta_ff     <= delta_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      kbits_ff     <= kbits_in;
      prod_ff      <= prod_in;
      low_ff       <= low_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      sat_ff       <= sat_in;
      out_angle_ff <= out_angle_in;
      out_pos_ff   <= out_pos_in;
      out_vel_ff   <= out_vel_in;
      out_ok_ff    <= out_ok_in;
      out_mag_ff   <= out_mag_in;
      out_ivl_ff   <= out_ivl_in;
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff         <= CPR_RESET;
         wrap_thr_ff    <= WRAP_RESET;
         ivl_max_ff     <= IVL_MAX_RESET;
         ivl_dflt_ff    <= IVL_DFLT_RESET;
         fix_pos_low_ff <= FIX_POS_RESET;
         fix_high_ff    <= FIX_HIGH_RESET;
         fix_neg_low_ff <= FIX_NEG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_COUNTS_PER_REV: cpr_ff         <= csr_wdata[14:0];
            REG_WRAP_THRESHOLD: wrap_thr_ff    <= csr_wdata[14:0];
            REG_INTERVAL_MAX:   ivl_max_ff     <= csr_wdata;
            REG_INTERVAL_DFLT:  ivl_dflt_ff    <= csr_wdata[19:0];
            REG_FIX_POS_LOW:    fix_pos_low_ff <= csr_wdata[15:0];
            REG_FIX_HIGH:       fix_high_ff    <= csr_wdata[15:0];
            REG_FIX_NEG_LOW:    fix_neg_low_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Channel ports
   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.angle_counts    = out_angle_ff;
   assign rsp_chan.position_counts = $signed(out_pos_ff);
   assign rsp_chan.velocity_cps    = $signed(out_vel_ff);
   assign rsp_chan.parity_ok       = out_ok_ff;
   assign rsp_chan.no_magnet       = out_mag_ff;
   assign rsp_chan.interval_us     = out_ivl_ff;

   // Checks
   `EMV_ASSERT_NEXT(a_accept_starts, accept, state_ff == S_FRONT, "accepted item did not start")
   `EMV_ASSERT_NOW(a_rem_below_dt, state_ff == S_DIV, rem_ff < dt_ff, "divider remainder not below interval")
   `EMV_ASSERT_NEXT(a_done_holds, state_ff == S_DONE && out_valid_ff && !rsp_chan.ready, state_ff == S_DONE, "result step left while output full")
   `EMV_ASSERT_NOW(a_interval_nonzero, out_valid_ff, out_ivl_ff != 32'd0, "zero interval reported")

endmodule

// ===== bench/tb_encoder_multiturn_velocity_unit.sv =====
// Self-checking bench for the multi-turn encoder position and velocity unit.
// Drives samples, predicts each result from tracked state or takes a hand-worked one, and compares them.
// Depends on emv_pkg, emv_req_if, emv_rsp_if and encoder_multiturn_velocity_unit.
module tb_encoder_multiturn_velocity_unit import emv_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 100;

   // One result item as the unit reports it
   typedef struct packed {
      logic        [ANGLE_W-1:0] angle;
      logic signed [POS_W-1:0]   position;
      logic signed [31:0]        velocity;
      logic                      parity_ok;
      logic                      no_magnet;
      logic        [31:0]        interval;
   } encoder_reading_type;

   // Directed sample with an optional hand-worked reading
   typedef struct packed {
      logic [15:0]         word;
      logic [31:0]         stamp;
      logic                typed;
      encoder_reading_type want;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [15] = '{
      // first sample after reset: zero velocity, default interval
      '{16'h0000, 32'd1000, 1'b1, '{14'd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 32'd100}},
      '{16'h0191, 32'd2000, 1'b0, '0},
      // bad parity: angle and flag hold
      '{16'hFFFE, 32'd3000, 1'b1, '{14'd100, 32'sd100, 32'sd0, 1'b0, 1'b0, 32'd1000}},
      // full-scale angle with no magnet, equal timestamp, wrap back one turn
      '{16'hFFFF, 32'd3000, 1'b1,
        '{14'd16383, -32'sd1, -32'sd1010000, 1'b1, 1'b1, 32'd100}},
      // interval one above the maximum, wrap forward one turn
      '{16'h0000, 32'd503001, 1'b1, '{14'd0, 32'sd0, 32'sd10000, 1'b1, 1'b0, 32'd100}},
      '{16'h0000, 32'hFFFF_FFFF, 1'b1, '{14'd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 32'd100}},
      // timestamp rolls over to zero: measured interval is zero
      '{16'h0000, 32'd0, 1'b1, '{14'd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 32'd100}},
      // one microsecond apart: positive and negative saturation
      '{16'h7D00, 32'd1, 1'b1,
        '{14'd8000, 32'sd8000, 32'sh7FFF_FFFF, 1'b1, 1'b0, 32'd1}},
      '{16'h0000, 32'd2, 1'b1,
        '{14'd0, 32'sd0, 32'sh8000_0000, 1'b1, 1'b0, 32'd1}},
      // interval exactly at the maximum
      '{16'h0003, 32'd500002, 1'b1, '{14'd0, 32'sd0, 32'sd0, 1'b1, 1'b1, 32'd500000}},
      '{16'h0001, 32'd500003, 1'b1, '{14'd0, 32'sd0, 32'sd0, 1'b0, 1'b1, 32'd1}},
      '{16'hFFFC, 32'd600000, 1'b0, '0},
      '{16'h5555, 32'd600100, 1'b0, '0},
      '{16'hAAAA, 32'd600101, 1'b0, '0},
      '{16'h8000, 32'd600200, 1'b0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   emv_req_if req_chan ();
   emv_rsp_if rsp_chan ();

   encoder_multiturn_velocity_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the configuration registers
   logic [14:0] rev_counts   = CPR_RESET;
   logic [14:0] wrap_limit   = WRAP_RESET;
   logic [31:0] span_max     = IVL_MAX_RESET;
   logic [19:0] span_default = IVL_DFLT_RESET;
   logic [15:0] fold_pos_low = FIX_POS_RESET;
   logic [15:0] fold_high    = FIX_HIGH_RESET;
   logic [15:0] fold_neg_low = FIX_NEG_RESET;

   // Tracked encoder state
   logic [ANGLE_W-1:0] cur_angle      = '0;
   logic [ANGLE_W-1:0] prev_angle     = '0;
   logic               magnet_latched = 1'b0;
   logic [POS_W-1:0]   turn_base      = '0;
   logic [POS_W-1:0]   prev_position  = '0;
   logic [31:0]        prev_stamp     = '0;
   logic               seen_first     = 1'b0;

   encoder_reading_type pending_readings [$];
   int                  mismatch_count  = 0;
   int                  readings_seen   = 0;
   bit                  idling_on       = 1'b1;
   bit                  hold_request    = 1'b0;

   // Random trajectory of the shaft and of the sample clock
   logic [ANGLE_W-1:0] shaft_angle = '0;
   logic [31:0]        sample_time = '0;

   // Work out the reading one sample causes and advance the tracked state
   function automatic encoder_reading_type track_sample(input logic [15:0] word,
                                                        input logic [31:0] stamp);
      encoder_reading_type r;
      longint              jump;
      longint              delta;
      longint              rate;
      longint unsigned     mag;
      longint unsigned     quot;
      logic [POS_W-1:0]    position;
      logic [31:0]         span;
      logic [31:0]         fallback;
      logic                good;
      logic                neg;
      good = ~^word;
      if (good) begin
         cur_angle      = word[15:2];
         magnet_latched = word[1];
      end
      // count a turn against any jump beyond the threshold
      jump = longint'(cur_angle) - longint'(prev_angle);
      if (jump > longint'(wrap_limit) || -jump > longint'(wrap_limit)) begin
         if (jump > 0)
            turn_base = turn_base - 32'(rev_counts);
         else
            turn_base = turn_base + 32'(rev_counts);
      end
      prev_angle = cur_angle;
      position   = turn_base + 32'(cur_angle);
      // measure the interval; a stamp not ahead of the last one wraps
      if (stamp > prev_stamp)
         span = stamp - prev_stamp;
      else
         span = 32'hFFFF_FFFF - prev_stamp + stamp;
      fallback = (span_default == '0) ? 32'd1 : 32'(span_default);
      if (span == 0 || span > span_max)
         span = fallback;
      rate = 0;
      if (seen_first) begin
         delta = longint'($signed(position)) - longint'($signed(prev_position));
         // near-one-revolution fold, positive side first
         if (delta > longint'(fold_pos_low) && delta < longint'(fold_high))
            delta -= longint'(rev_counts);
         if (delta > -longint'(fold_high) && delta < -longint'(fold_neg_low))
            delta += longint'(rev_counts);
         neg  = delta < 0;
         mag  = neg ? -delta : delta;
         quot = mag * 64'd1000000 / span;
         if (neg) begin
            if (quot > 64'd2147483648)
               quot = 64'd2147483648;
            rate = -longint'(quot);
         end else begin
            if (quot > 64'd2147483647)
               quot = 64'd2147483647;
            rate = longint'(quot);
         end
      end else begin
         span = fallback;
      end
      prev_position = position;
      prev_stamp    = stamp;
      seen_first    = 1'b1;
      r.angle     = cur_angle;
      r.position  = position;
      r.velocity  = rate[31:0];
      r.parity_ok = good;
      r.no_magnet = magnet_latched;
      r.interval  = span;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("%0t: reading %0d %s: got %0d, expected %0d",
               $time, readings_seen, what, got, want);
   endtask

   // Compare one accepted reading with the oldest one expected
   task automatic check_reading();
      encoder_reading_type want;
      readings_seen++;
      if (pending_readings.size() == 0) begin
         report_mismatch("unexpected reading", 0, 0);
         return;
      end
      want = pending_readings.pop_front();
      if (rsp_chan.angle_counts !== want.angle)
         report_mismatch("angle_counts", rsp_chan.angle_counts, want.angle);
      if (rsp_chan.position_counts !== want.position)
         report_mismatch("position_counts", rsp_chan.position_counts, want.position);
      if (rsp_chan.velocity_cps !== want.velocity)
         report_mismatch("velocity_cps", rsp_chan.velocity_cps, want.velocity);
      if (rsp_chan.parity_ok !== want.parity_ok)
         report_mismatch("parity_ok", rsp_chan.parity_ok, want.parity_ok);
      if (rsp_chan.no_magnet !== want.no_magnet)
         report_mismatch("no_magnet", rsp_chan.no_magnet, want.no_magnet);
      if (rsp_chan.interval_us !== want.interval)
         report_mismatch("interval_us", rsp_chan.interval_us, want.interval);
   endtask

   // Offer one sample, hold it until accepted, then queue its reading
   task automatic offer_sample(input logic [15:0] word, input logic [31:0] stamp,
                               input logic typed, input encoder_reading_type want);
      encoder_reading_type predicted;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sample_word  <= word;
      req_chan.timestamp_us <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      predicted = track_sample(word, stamp);
      pending_readings.push_back(typed ? want : predicted);
   endtask

   // Mostly a smooth shaft with good parity; some broken words and odd timing
   task automatic random_samples(input int count);
      logic [14:0] body;
      logic [15:0] word;
      int          pick;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            shaft_angle = 14'($urandom_range(0, 16383));
         else
            shaft_angle = shaft_angle + 14'($urandom_range(0, 6000)) - 14'd3000;
         body = {shaft_angle, 1'($urandom_range(0, 9) == 0)};
         pick = $urandom_range(0, 99);
         if (pick < 80)
            word = {body, ^body};
         else if (pick < 90)
            word = {body, ~^body};
         else
            word = 16'($urandom_range(0, 65535));
         pick = $urandom_range(0, 99);
         if (pick < 65)
            sample_time = sample_time + 32'($urandom_range(1, 3000));
         else if (pick < 72)
            sample_time = sample_time;
         else if (pick < 78)
            sample_time = sample_time + 32'($urandom_range(1, 3));
         else if (pick < 85)
            sample_time = sample_time + 32'($urandom_range(400000, 5000000));
         else if (pick < 92)
            sample_time = $urandom;
         else
            sample_time = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
         offer_sample(word, sample_time, 1'b0, '0);
      end
   endtask

   // Drop valid and wait for every queued reading to come back
   task automatic drain_readings();
      req_chan.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] reg_index, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      case (reg_index)
         REG_COUNTS_PER_REV: rev_counts   = value[14:0];
         REG_WRAP_THRESHOLD: wrap_limit   = value[14:0];
         REG_INTERVAL_MAX:   span_max     = value;
         REG_INTERVAL_DFLT:  span_default = value[19:0];
         REG_FIX_POS_LOW:    fold_pos_low = value[15:0];
         REG_FIX_HIGH:       fold_high    = value[15:0];
         REG_FIX_NEG_LOW:    fold_neg_low = value[15:0];
         default: ;
      endcase
   endtask

   task automatic program_registers(input logic [31:0] cpr, input logic [31:0] wrap,
                                    input logic [31:0] imax, input logic [31:0] idflt,
                                    input logic [31:0] fpos, input logic [31:0] fhigh,
                                    input logic [31:0] fneg);
      write_reg(REG_COUNTS_PER_REV, cpr);
      write_reg(REG_WRAP_THRESHOLD, wrap);
      write_reg(REG_INTERVAL_MAX, imax);
      write_reg(REG_INTERVAL_DFLT, idflt);
      write_reg(REG_FIX_POS_LOW, fpos);
      write_reg(REG_FIX_HIGH, fhigh);
      write_reg(REG_FIX_NEG_LOW, fneg);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Result side: check each item, stall in random bursts or on request
   initial begin : reading_sink
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            check_reading();
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end else if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // End the run after too long without any handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("encoder_multiturn_velocity_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      req_chan.valid        = 1'b0;
      req_chan.sample_word  = '0;
      req_chan.timestamp_us = '0;
      csr_we    = 1'b0;
      csr_index = REG_COUNTS_PER_REV;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // register defaults: directed rows, then random samples
      foreach (DIRECTED_ROWS[i])
         offer_sample(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].stamp,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      sample_time = 32'd600200;
      random_samples(60);
      drain_readings();

      // no turn counting, every fold window live; hold off results to fill the unit
      program_registers(32'd16384, 32'd16384, 32'hFFFF_FFFF, 32'd1000000,
                        32'd13768, 32'd21591, 32'd11160);
      hold_request = 1'b1;
      random_samples(60);
      drain_readings();

      // zero revolution, zero threshold, default interval of zero
      program_registers(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd65535, 32'd0);
      random_samples(40);
      drain_readings();

      // one-count revolution, widest default, empty fold windows
      program_registers(32'd1, 32'd8192, 32'd1000, 32'hF_FFFF, 32'hFFFF, 32'd0, 32'hFFFF);
      random_samples(40);
      drain_readings();

      // full-scale revolution and threshold fields, wide fold windows
      program_registers(32'h7FFF, 32'h7FFF, 32'd200000, 32'd50, 32'd100, 32'd40000, 32'd200);
      random_samples(40);
      drain_readings();

      // random settings
      program_registers(32'($urandom_range(1, 16384)), 32'($urandom_range(0, 16384)),
                        32'($urandom_range(1000, 2000000)), 32'($urandom_range(1, 1000000)),
                        32'($urandom_range(8000, 16000)), 32'($urandom_range(16000, 30000)),
                        32'($urandom_range(8000, 16000)));
      random_samples(60);
      drain_readings();

      // back to the defaults with both sides running flat out
      program_registers(32'(CPR_RESET), 32'(WRAP_RESET), IVL_MAX_RESET, 32'(IVL_DFLT_RESET),
                        32'(FIX_POS_RESET), 32'(FIX_HIGH_RESET), 32'(FIX_NEG_RESET));
      idling_on = 1'b0;
      random_samples(100);
      drain_readings();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("encoder_multiturn_velocity_unit regression: pass");
      else
         $display("encoder_multiturn_velocity_unit regression: fail");
      $finish;
   end

endmodule
